/* sv/tfh_pkg.sv */
// Shared types, constants and helper functions for the two-choice fingerprint hash table.
package tfh_pkg;

	localparam int unsigned MAX_PAIRS     = 1024;
	localparam int unsigned PAIR_W        = 10;
	localparam int unsigned SLOT_DEPTH    = 2048;
	localparam int unsigned SLOT_AW       = 11;
	localparam int unsigned SLOT_W        = 32;
	localparam int unsigned CAP_W         = 11;
	localparam int unsigned HALF_W        = 9;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;
	localparam logic [HALF_W-1:0] HALF_RESET = 9'd256;

	localparam logic [31:0] SEED_LEFT  = 32'he65ac2d3;
	localparam logic [31:0] SEED_RIGHT = 32'ha96347c5;
	localparam logic [63:0] KEY_LEN    = 64'd8;

	localparam logic [63:0] MUL_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MUL_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] MUL_M1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MUL_M2 = 64'hc4ceb9fe1a85ec53;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_MISS     = 2'd1;
	localparam logic [1:0] STAT_CAP_FULL = 2'd2;
	localparam logic [1:0] STAT_BKT_FULL = 2'd3;

	typedef enum logic [0:0] {
		HS_IDLE,
		HS_RUN
	} hsh_state_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD,
		ST_CHK,
		ST_CMP,
		ST_WR,
		ST_RESP
	} tbl_state_t;

	typedef struct packed {
		logic [63:0] lo0;
		logic [63:0] lo1;
		logic [31:0] hi0;
		logic [31:0] hi1;
	} hash_res_t;

	function automatic logic [63:0] mul_const(input logic [2:0] step);
		logic [63:0] c;
		case (step)
			3'd0: c = MUL_C1;
			3'd1: c = MUL_C2;
			3'd2: c = MUL_M1;
			3'd3: c = MUL_M2;
			3'd4: c = MUL_M1;
			default: c = MUL_M2;
		endcase
		return c;
	endfunction

	function automatic logic [HALF_W-1:0] half_of(input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0]  c;
		logic [HALF_W-1:0] hb;
		c  = (cap > CAP_RESET) ? CAP_RESET : cap;
		hb = 9'd4;
		for (int i = 0; i < 7; i++) begin
			if ({hb, 3'b000} <= {1'b0, c})
				hb = {hb[HALF_W-2:0], 1'b0};
		end
		return hb;
	endfunction

endpackage

/* sv/two_choice_fingerprint_hash_table.sv */
// Top level of the two-choice fingerprint hash table: sequencer and table memories.
//
// Usage: raise start with op, key and value while busy is low; the transaction is
// taken at that clock edge. op 0 looks the key up, op 1 stores the key/value pair.
// Each transaction gives exactly one result unless a capacity write aborts it:
// done is high for one cycle with status, pair_index and value_out; the receiver cannot stall it.
// Sequence, from the accept edge to the result: hashing (two seeds, six 64-bit
// multiplies each on one 32x32 multiplier, then the hash done strobe), then a
// read and a check of each slot visited in the left and right buckets (up to
// eight), a stored-key check after each fingerprint hit on a lookup, a write
// step on an insert, a response step and the result cycle. An insert refused
// at capacity skips the slot visits. busy drops in the result cycle, so the
// next transaction can be taken at the edge that ends it. One transaction is
// in flight at a time.
// The slot memory has one synchronous write port and one synchronous read port;
// key and value memories are valid up to the pair fill count, so only the slot
// memory is swept. Reset and every capacity write (cfg_we, cfg_wdata) start a
// clearing pass over all 2048 slot memory entries, during which busy is high.
module two_choice_fingerprint_hash_table import tfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [63:0]       key,
	input  logic [63:0]       value,
	output logic              done,
	output logic [1:0]        status,
	output logic [PAIR_W-1:0] pair_index,
	output logic [63:0]       value_out,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata
);

	logic [SLOT_W-1:0] slot_mem [SLOT_DEPTH];
	logic [63:0]       key_mem  [MAX_PAIRS];
	logic [63:0]       val_mem  [MAX_PAIRS];

	tbl_state_t        state_q, state_d;
	logic [CAP_W-1:0]  cap_q, np_q, eff_cap;
	logic [HALF_W-1:0] hb_q;
	logic [SLOT_AW-1:0] clr_q;
	logic [2:0]        hs_q;
	logic [2:0]        n0_q, n1_q;
	logic [1:0]        last0_q, last1_q;
	logic              op_q, kv_ok_q, done_q;
	logic [63:0]       key_q, val_q, key_rd, val_rd;
	logic [PAIR_W-1:0] k_q;
	logic [SLOT_W-1:0] slot_rd;
	logic [1:0]        stat_q;
	logic [PAIR_W-1:0] pidx_q;
	logic [63:0]       vout_q;

	logic              hash_start, hash_done;
	hash_res_t         hres;

	logic [7:0]        hbm;
	logic [HALF_W-1:0] b0, b1, bsel, bwr;
	logic [SLOT_AW-1:0] mask;
	logic [31:0]       fp0, fp1, fph, fpw;
	logic [SLOT_AW-1:0] kfull;
	logic              slot_hit, key_hit, last_slot, cap_full, put_left, none_free;
	logic [63:0]       key_cmp;
	logic              slot_we, slot_re;
	logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
	logic [SLOT_W-1:0] slot_wdata;
	logic              pair_we;

	tfh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key),
		.done   (hash_done),
		.res    (hres)
	);

	always_comb begin
		eff_cap   = (cap_q > CAP_RESET) ? CAP_RESET : cap_q;
		hbm       = 8'(hb_q - 9'd1);
		mask      = 11'({hb_q, 3'b000} - 12'd1);
		b0        = {1'b0, hres.lo0[7:0] & hbm};
		b1        = {1'b0, hres.lo1[7:0] & hbm} + hb_q;
		fp0       = hres.hi0 & ~{21'h0, mask};
		fp1       = hres.hi1 & ~{21'h0, mask};
		bsel      = hs_q[2] ? b1 : b0;
		fph       = hs_q[2] ? fp1 : fp0;
		kfull     = slot_rd[SLOT_AW-1:0] & mask;
		slot_hit  = ((slot_rd & ~{21'h0, mask}) == fph) && !kfull[SLOT_AW-1];
		key_cmp   = kv_ok_q ? key_rd : 64'h0;
		key_hit   = (key_cmp == key_q);
		last_slot = (hs_q == 3'd7);
		cap_full  = (np_q >= eff_cap);
		put_left  = (n0_q >= n1_q);
		none_free = (n0_q == 3'd0) && (n1_q == 3'd0);
		bwr       = put_left ? b0 : b1;
		fpw       = put_left ? fp0 : fp1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == SLOT_AW'(SLOT_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_HASH;
			ST_HASH: begin
				if (hash_done)
					state_d = (op_q == OP_PUT && cap_full) ? ST_RESP : ST_RD;
			end
			ST_RD: state_d = ST_CHK;
			ST_CHK: begin
				if (op_q == OP_GET && slot_hit)
					state_d = ST_CMP;
				else if (last_slot)
					state_d = (op_q == OP_PUT) ? ST_WR : ST_RESP;
				else
					state_d = ST_RD;
			end
			ST_CMP: state_d = (key_hit || last_slot) ? ST_RESP : ST_RD;
			ST_WR:  state_d = ST_RESP;
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we)
			state_d = ST_CLEAR;
	end

	always_comb begin
		busy       = (state_q != ST_IDLE);
		hash_start = (state_q == ST_IDLE) && start;
		slot_re    = (state_q == ST_RD);
		slot_raddr = {bsel, hs_q[1:0]};
		pair_we    = (state_q == ST_WR) && !none_free;
		slot_we    = (state_q == ST_CLEAR) || pair_we;
		slot_waddr = (state_q == ST_CLEAR) ? clr_q : {bwr, put_left ? last0_q : last1_q};
		slot_wdata = (state_q == ST_CLEAR) ? '0 : (fpw | {21'h0, np_q & mask});
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re)
			slot_rd <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (pair_we) begin
			key_mem[np_q[PAIR_W-1:0]] <= key_q;
			val_mem[np_q[PAIR_W-1:0]] <= val_q;
		end
		key_rd <= key_mem[kfull[PAIR_W-1:0]];
		val_rd <= val_mem[kfull[PAIR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cap_q   <= CAP_RESET;
			hb_q    <= HALF_RESET;
			np_q    <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_RESP);
			if (cfg_we) begin
				cap_q <= cfg_wdata;
				hb_q  <= half_of(cfg_wdata);
				np_q  <= '0;
				clr_q <= '0;
			end else begin
				if (state_q == ST_CLEAR)
					clr_q <= clr_q + 11'd1;
				if (pair_we)
					np_q <= np_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q  <= op;
					key_q <= key;
					val_q <= value;
				end
			end
			ST_HASH: begin
				hs_q    <= '0;
				n0_q    <= '0;
				n1_q    <= '0;
				last0_q <= '0;
				last1_q <= '0;
				stat_q  <= (op_q == OP_PUT) ? STAT_CAP_FULL : STAT_MISS;
				pidx_q  <= '0;
				vout_q  <= '0;
			end
			ST_CHK: begin
				k_q     <= kfull[PAIR_W-1:0];
				kv_ok_q <= (kfull < np_q);
				if (op_q == OP_PUT && slot_rd == '0) begin
					if (hs_q[2]) begin
						n1_q    <= n1_q + 3'd1;
						last1_q <= hs_q[1:0];
					end else begin
						n0_q    <= n0_q + 3'd1;
						last0_q <= hs_q[1:0];
					end
				end
				if (!(op_q == OP_GET && slot_hit))
					hs_q <= hs_q + 3'd1;
			end
			ST_CMP: begin
				hs_q <= hs_q + 3'd1;
				if (key_hit) begin
					stat_q <= STAT_OK;
					pidx_q <= k_q;
					vout_q <= kv_ok_q ? val_rd : 64'h0;
				end
			end
			ST_WR: begin
				if (none_free) begin
					stat_q <= STAT_BKT_FULL;
				end else begin
					stat_q <= STAT_OK;
					pidx_q <= np_q[PAIR_W-1:0];
				end
			end
			ST_RESP: begin
				status     <= stat_q;
				pair_index <= pidx_q;
				value_out  <= vout_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;

endmodule

/* sv/tfh_hash.sv */
// Sequential 128-bit MurmurHash3 x64 of an 8-byte key for both seeds on one 32x32 multiplier.
module tfh_hash import tfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output hash_res_t   res
);

	hsh_state_t  state_q, state_d;
	logic [2:0]  step_q;
	logic [1:0]  ph_q;
	logic        side_q;
	logic        done_q;
	logic        last;
	logic [63:0] a_q, p_q, h1_q, h2_q, key_q;
	logic [63:0] c, seed, h1a, h2a, h1b, h2b, pm, f2, lo, hi;
	logic [31:0] opa, opb;
	logic [63:0] prod;

	always_comb begin
		state_d = state_q;
		case (state_q)
			HS_IDLE: if (start) state_d = HS_RUN;
			HS_RUN:  if (last) state_d = HS_IDLE;
			default: state_d = HS_IDLE;
		endcase
	end

	always_comb begin
		last = (state_q == HS_RUN) && (ph_q == 2'd3) && (step_q == 3'd5) && side_q;
	end

	always_comb begin
		c = mul_const(step_q);
		case (ph_q)
			2'd0: begin opa = a_q[31:0];  opb = c[31:0];  end
			2'd1: begin opa = a_q[31:0];  opb = c[63:32]; end
			default: begin opa = a_q[63:32]; opb = c[31:0]; end
		endcase
		prod = {32'h0, opa} * {32'h0, opb};
		seed = {32'h0, side_q ? SEED_RIGHT : SEED_LEFT};
		h1a  = seed ^ p_q ^ KEY_LEN;
		h2a  = seed ^ KEY_LEN;
		h1b  = h1a + h2a;
		h2b  = h2a + h1b;
		pm   = p_q ^ (p_q >> 33);
		f2   = pm;
		lo   = h1_q + f2;
		hi   = f2 + lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			step_q  <= '0;
			ph_q    <= '0;
			side_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last;
			if (state_q == HS_IDLE) begin
				step_q <= '0;
				ph_q   <= '0;
				side_q <= 1'b0;
			end else begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					if (step_q == 3'd5) begin
						step_q <= '0;
						side_q <= ~side_q;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == HS_IDLE) begin
			if (start) begin
				key_q <= key;
				a_q   <= key;
			end
		end else begin
			case (ph_q)
				2'd0: p_q <= prod;
				2'd1, 2'd2: p_q <= p_q + {prod[31:0], 32'h0};
				default: begin
					case (step_q)
						3'd0: a_q <= {p_q[32:0], p_q[63:33]};
						3'd1: begin
							h1_q <= h1b;
							h2_q <= h2b;
							a_q  <= h1b ^ (h1b >> 33);
						end
						3'd2: a_q <= pm;
						3'd3: begin
							h1_q <= pm;
							a_q  <= h2_q ^ (h2_q >> 33);
						end
						3'd4: a_q <= pm;
						default: begin
							a_q <= key_q;
							if (side_q) begin
								res.lo1 <= lo;
								res.hi1 <= hi[31:0];
							end else begin
								res.lo0 <= lo;
								res.hi0 <= hi[31:0];
							end
						end
					endcase
				end
			endcase
		end
	end

	assign done = done_q;

endmodule

/* sv/tfh_checker.sv */
// Port-level checker for the hash table, bound to the top level.
module tfh_checker import tfh_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        status,
	input logic [PAIR_W-1:0] pair_index,
	input logic [63:0]       value_out,
	input logic              cfg_we
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after accepted transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result right after accept");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> pair_index == '0 && value_out == '0)
		else $error("nonzero payload on failed transaction");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("not busy after capacity write");

endmodule

bind two_choice_fingerprint_hash_table tfh_checker u_tfh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.pair_index (pair_index),
	.value_out  (value_out),
	.cfg_we     (cfg_we)
);
